// ===== rtl/acr_pkg.sv =====
// ----------------------------------------------------------------------------
// acr_pkg
// Shared widths, policy codes, request types and helpers of the associative
// cache replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package acr_pkg;

	localparam int LINES_DEF = 16;
	localparam int TAG_W     = 20;
	localparam int CNT_W     = 16;
	localparam int IDX_W     = 4;
	localparam int POL_W     = 2;

	localparam logic [POL_W-1:0] POL_LRU  = 2'd0;
	localparam logic [POL_W-1:0] POL_LFU  = 2'd1;
	localparam logic [POL_W-1:0] POL_FIFO = 2'd2;

	// Classified request handed from the front to the back.
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             hit;
	} acr_cls_t;

	// One result as it waits in the output queue.
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] line_index;
		logic             evicted;
		logic [TAG_W-1:0] evicted_tag;
	} acr_res_t;

	localparam int RES_W = $bits(acr_res_t);

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (&c) ? c : c + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/acr_fifo.sv =====
// ----------------------------------------------------------------------------
// acr_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/acr_victim.sv =====
// ----------------------------------------------------------------------------
// acr_victim
// Registered selection tree that finds the replacement line: the first
// invalid line, else the first line with the least or greatest aged count.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_victim #(
	parameter int LINES = acr_pkg::LINES_DEF
) (
	input  wire logic                                   clk,
	input  wire logic [acr_pkg::POL_W-1:0]              policy,
	input  wire logic [LINES-1:0]                       valid,
	input  wire logic [LINES-1:0][acr_pkg::CNT_W-1:0]   counts,
	output logic [$clog2(LINES)-1:0]                    victim,
	output logic                                        victim_inv
);
	import acr_pkg::*;

	localparam int IW = $clog2(LINES);
	localparam int NP = 1 << IW;

	typedef struct packed {
		logic             live;
		logic             inv;
		logic [CNT_W-1:0] key;
		logic [IW-1:0]    idx;
	} node_t;

	// Left child wins ties, which keeps the lowest-numbered line.
	function automatic node_t pick(input node_t l, input node_t r, input logic least);
		logic take_r;
		take_r = 1'b0;
		if (r.live) begin
			if (!l.live) begin
				take_r = 1'b1;
			end else if (r.inv != l.inv) begin
				take_r = r.inv;
			end else if (!r.inv) begin
				take_r = least ? (r.key < l.key) : (r.key > l.key);
			end
		end
		return take_r ? r : l;
	endfunction

	logic  least;
	logic  ageing;
	node_t leaf   [NP];
	node_t node_q [NP-1];

	assign least  = (policy == POL_LFU);
	assign ageing = ~least;

	for (genvar g = 0; g < NP; g++) begin : g_leaf
		if (g < LINES) begin : g_real
			assign leaf[g] = '{live: 1'b1,
				inv: ~valid[g],
				key: (ageing && valid[g]) ? sat_inc(counts[g]) : counts[g],
				idx: IW'(g)};
		end else begin : g_pad
			assign leaf[g] = '0;
		end
	end

	for (genvar j = 0; j < NP - 1; j++) begin : g_node
		localparam int CL = 2 * j + 1;
		localparam int CR = 2 * j + 2;
		node_t l_w;
		node_t r_w;
		if (CL >= NP - 1) begin : g_lleaf
			assign l_w = leaf[CL-(NP-1)];
		end else begin : g_lnode
			assign l_w = node_q[CL];
		end
		if (CR >= NP - 1) begin : g_rleaf
			assign r_w = leaf[CR-(NP-1)];
		end else begin : g_rnode
			assign r_w = node_q[CR];
		end
		always_ff @(posedge clk) begin
			node_q[j] <= pick(l_w, r_w, least);
		end
	end

	assign victim     = node_q[0].idx;
	assign victim_inv = node_q[0].inv;

endmodule

`default_nettype wire

// ===== rtl/acr_front.sv =====
// ----------------------------------------------------------------------------
// acr_front
// Takes requests into a small queue, compares the oldest tag against every
// line and hands the classified request to the back through a one-entry slot.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_front #(
	parameter int LINES = acr_pkg::LINES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 push,
	input  wire logic [acr_pkg::TAG_W-1:0]            block_tag,
	output logic                                      full,
	input  wire logic [LINES-1:0]                     valid,
	input  wire logic [LINES-1:0][acr_pkg::TAG_W-1:0] tags,
	output logic                                      cls_valid,
	output acr_pkg::acr_cls_t                         cls,
	output logic [$clog2(LINES)-1:0]                  cls_line,
	input  wire logic                                 cls_take
);
	import acr_pkg::*;

	localparam int IW = $clog2(LINES);

	logic             in_empty;
	logic [TAG_W-1:0] head_tag;
	logic             load;
	logic             any_hit;
	logic [IW-1:0]    hit_line;
	logic             cls_valid_q;
	acr_cls_t         cls_s1;
	logic [IW-1:0]    line_s1;

	// The slot is only refilled once the back has consumed the previous
	// request, so the compare always sees the updated tag store.
	assign load = ~in_empty & ~cls_valid_q;

	acr_fifo #(
		.WIDTH(TAG_W),
		.DEPTH(2)
	) u_in_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (block_tag),
		.full  (full),
		.pop   (load),
		.rdata (head_tag),
		.empty (in_empty)
	);

	always_comb begin
		any_hit  = 1'b0;
		hit_line = '0;
		for (int i = LINES - 1; i >= 0; i--) begin
			if (valid[i] && tags[i] == head_tag) begin
				any_hit  = 1'b1;
				hit_line = IW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cls_s1.tag <= head_tag;
			cls_s1.hit <= any_hit;
			line_s1    <= hit_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_valid_q <= 1'b0;
		end else if (load) begin
			cls_valid_q <= 1'b1;
		end else if (cls_take) begin
			cls_valid_q <= 1'b0;
		end
	end

	assign cls_valid = cls_valid_q;
	assign cls       = cls_s1;
	assign cls_line  = line_s1;

endmodule

`default_nettype wire

// ===== rtl/acr_back.sv =====
// ----------------------------------------------------------------------------
// acr_back
// Holds the tag store and counters, carries out hits and installs, and
// queues the results.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_back #(
	parameter int LINES = acr_pkg::LINES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [acr_pkg::POL_W-1:0]            policy,
	input  wire logic                                 policy_wr,
	input  wire logic                                 cls_valid,
	input  wire acr_pkg::acr_cls_t                    cls,
	input  wire logic [$clog2(LINES)-1:0]             cls_line,
	output logic                                      cls_take,
	output logic [LINES-1:0]                          valid,
	output logic [LINES-1:0][acr_pkg::TAG_W-1:0]      tags,
	input  wire logic                                 pop,
	output logic                                      empty,
	output acr_pkg::acr_res_t                         res
);
	import acr_pkg::*;

	localparam int IW = $clog2(LINES);
	localparam int SW = $clog2(IW + 1);

	logic [LINES-1:0]             valid_q;
	logic [LINES-1:0][TAG_W-1:0]  tags_q;
	logic [LINES-1:0][CNT_W-1:0]  cnt_q;
	logic [LINES-1:0]             valid_d;
	logic [LINES-1:0][TAG_W-1:0]  tags_d;
	logic [LINES-1:0][CNT_W-1:0]  cnt_d;
	logic [SW-1:0]                settle_q;
	logic                         settled;
	logic [IW-1:0]                victim;
	logic                         victim_inv;
	logic                         res_full;
	logic                         fire;
	logic                         lfu;
	logic                         lru;
	logic [IW-1:0]                line;
	acr_res_t                     res_d;
	logic [RES_W-1:0]             res_raw;

	acr_victim #(
		.LINES(LINES)
	) u_victim (
		.clk       (clk),
		.policy    (policy),
		.valid     (valid_q),
		.counts    (cnt_q),
		.victim    (victim),
		.victim_inv(victim_inv)
	);

	// The tree must settle level by level after any change of its inputs.
	assign settled  = (settle_q == SW'(IW));
	assign fire     = cls_valid & (cls.hit | settled) & ~res_full;
	assign cls_take = fire;
	assign lfu      = (policy == POL_LFU);
	assign lru      = (policy == POL_LRU);
	assign line     = cls.hit ? cls_line : victim;

	always_comb begin
		for (int i = 0; i < LINES; i++) begin
			valid_d[i] = valid_q[i];
			tags_d[i]  = tags_q[i];
			cnt_d[i]   = (!lfu && valid_q[i]) ? sat_inc(cnt_q[i]) : cnt_q[i];
			if (line == IW'(i)) begin
				if (cls.hit) begin
					if (lfu) begin
						cnt_d[i] = sat_inc(cnt_q[i]);
					end else if (lru) begin
						cnt_d[i] = '0;
					end
				end else begin
					cnt_d[i]   = '0;
					valid_d[i] = 1'b1;
					tags_d[i]  = cls.tag;
				end
			end
		end
	end

	always_comb begin
		res_d.hit         = cls.hit;
		res_d.line_index  = IDX_W'(line);
		res_d.evicted     = ~cls.hit & ~victim_inv;
		res_d.evicted_tag = (~cls.hit & ~victim_inv) ? tags_q[victim] : '0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			tags_q <= tags_d;
			cnt_q  <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			settle_q <= '0;
		end else begin
			if (fire) begin
				valid_q <= valid_d;
			end
			if (fire || policy_wr) begin
				settle_q <= '0;
			end else if (!settled) begin
				settle_q <= settle_q + SW'(1);
			end
		end
	end

	acr_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fire),
		.wdata (res_d),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_raw),
		.empty (empty)
	);

	assign res   = acr_res_t'(res_raw);
	assign valid = valid_q;
	assign tags  = tags_q;

endmodule

`default_nettype wire

// ===== rtl/assoc_cache_replacement.sv =====
// ----------------------------------------------------------------------------
// assoc_cache_replacement
// Tag store of a fully associative cache level with LRU, LFU or FIFO
// replacement; reports hit, line and displaced tag for every access.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// request   in         push / full          block_tag
// result    out        pop / empty          hit, line_index, evicted, evicted_tag
// config    in         cfg_valid/cfg_ready  cfg_data (policy)
//
// A hit passes the parallel tag compare, registered into the front slot, and then
// the update in the back. A miss also waits until the registered victim tree
// has settled level by level after each store update or policy write.
// Reset clears all lines to invalid and the policy to LRU; no clearing pass.
// Two-entry queues on the request and result sides absorb stalls on either.
// ----------------------------------------------------------------------------
`default_nettype none

module assoc_cache_replacement #(
	parameter int LINES = acr_pkg::LINES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [acr_pkg::TAG_W-1:0]     block_tag,
	output logic                               empty,
	input  wire logic                          pop,
	output logic                               hit,
	output logic [acr_pkg::IDX_W-1:0]          line_index,
	output logic                               evicted,
	output logic [acr_pkg::TAG_W-1:0]          evicted_tag,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [acr_pkg::POL_W-1:0]     cfg_data
);
	import acr_pkg::*;

	localparam int IW = $clog2(LINES);

	logic [POL_W-1:0]            policy_q;
	logic                        cfg_fire;
	logic                        cls_valid;
	acr_cls_t                    cls;
	logic [IW-1:0]               cls_line;
	logic                        cls_take;
	logic [LINES-1:0]            valid;
	logic [LINES-1:0][TAG_W-1:0] tags;
	acr_res_t                    res;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_LRU;
		end else if (cfg_fire) begin
			policy_q <= cfg_data;
		end
	end

	acr_front #(
		.LINES(LINES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.block_tag(block_tag),
		.full     (full),
		.valid    (valid),
		.tags     (tags),
		.cls_valid(cls_valid),
		.cls      (cls),
		.cls_line (cls_line),
		.cls_take (cls_take)
	);

	acr_back #(
		.LINES(LINES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.policy   (policy_q),
		.policy_wr(cfg_fire),
		.cls_valid(cls_valid),
		.cls      (cls),
		.cls_line (cls_line),
		.cls_take (cls_take),
		.valid    (valid),
		.tags     (tags),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	assign hit         = res.hit;
	assign line_index  = res.line_index;
	assign evicted     = res.evicted;
	assign evicted_tag = res.evicted_tag;

endmodule

`default_nettype wire
